@@ sv/plc_pkg.sv @@
// Shared types and constants for the positional list core.
`default_nettype none

package plc_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 16;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int ENTRY_W      = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,   // cells above slot take left neighbor, slot takes value
    CELL_DEL,   // cells at and above slot take right neighbor
    CELL_ROT    // cells below slot take right neighbor, slot takes value
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t                 kind;
    logic signed [DATA_W-1:0]   value;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/plc_if.sv @@
// Valid/ready channel interfaces for commands and responses.
`default_nettype none

interface plc_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [plc_pkg::OP_W-1:0]               op;
  logic signed [plc_pkg::DATA_W-1:0]      item_value;
  logic [plc_pkg::POS_W-1:0]              position;

  modport source (output valid, op, item_value, position, input ready);
  modport sink   (input valid, op, item_value, position, output ready);
endinterface

interface plc_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [plc_pkg::DATA_W-1:0]      out_value;
  logic [plc_pkg::STATUS_W-1:0]           status;
  logic [plc_pkg::ENTRY_W-1:0]            entry_count;
  logic                                   last;

  modport source (output valid, out_value, status, entry_count, last, input ready);
  modport sink   (input valid, out_value, status, entry_count, last, output ready);
endinterface

`default_nettype wire

@@ sv/plc_cell.sv @@
// One storage cell of the shifting list.
`default_nettype none

module plc_cell #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  wire                                  clk,
  input  wire  plc_pkg::cell_ctl_t             ctl,
  input  wire  [IDX_W-1:0]                     slot,
  input  wire  signed [plc_pkg::DATA_W-1:0]    left,
  input  wire  signed [plc_pkg::DATA_W-1:0]    right,
  output logic signed [plc_pkg::DATA_W-1:0]    data
);
  import plc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.kind)
      CELL_INS: begin
        if (MY_IDX > slot) data_next = left;
        else if (MY_IDX == slot) data_next = ctl.value;
      end
      CELL_DEL: begin
        if (MY_IDX >= slot) data_next = right;
      end
      CELL_ROT: begin
        if (MY_IDX < slot) data_next = right;
        else if (MY_IDX == slot) data_next = ctl.value;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

@@ sv/positional_list_insert_delete_core.sv @@
// Positional list core: a row of shifting cells with insert, delete and dump.
// Insert, delete and unknown ops: result registered in the cycle after the command
//   transfer; a new command is taken every cycle while the response side drains.
// Dump: one response per stored entry, one per cycle while the response side drains;
//   the command side is held until the last one is loaded (not held if the list is empty).
// Reset (rst, synchronous) clears the entry count, the sequencer and the response
//   valid; cell contents are left as they are and only cells below the count are read.
`default_nettype none

module positional_list_insert_delete_core #(
  parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
  input wire         clk,
  input wire         rst,
  plc_cmd_if.sink    cmd,
  plc_rsp_if.source  rsp
);
  import plc_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  // Sequencer and count
  state_t             state, state_next;
  logic [CNT_W-1:0]   occ, occ_next;
  logic [IDX_W-1:0]   dump_idx, dump_idx_next;

  // Cell row
  cell_ctl_t                cell_ctl;
  logic [IDX_W-1:0]         cell_slot;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  // Response register contents
  logic                     res_load;
  logic signed [DATA_W-1:0] res_value;
  logic [STATUS_W-1:0]      res_status;
  logic [CNT_W-1:0]         res_count;
  logic                     res_last;

  logic                     accept;
  logic                     out_free;
  logic                     full;
  logic [POS_W-1:0]         occ_wide;
  logic [POS_W-1:0]         pos_slot;
  logic [IDX_W-1:0]         ins_slot;
  logic [IDX_W-1:0]         del_slot;
  logic [IDX_W-1:0]         last_idx;

  assign out_free  = !rsp.valid || rsp.ready;
  assign cmd.ready = (state == ST_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;

  assign full     = (occ == CNT_W'(CAPACITY));
  assign occ_wide = POS_W'(occ);
  // Position 0 and 1 both mean the head.
  assign pos_slot = (cmd.position <= POS_W'(1)) ? '0 : cmd.position - POS_W'(1);
  // Insert past the end appends; delete past the end removes the tail.
  assign ins_slot = (pos_slot > occ_wide) ? IDX_W'(occ) : IDX_W'(pos_slot);
  assign del_slot = (pos_slot >= occ_wide) ? IDX_W'(occ - CNT_W'(1)) : IDX_W'(pos_slot);
  assign last_idx = IDX_W'(occ - CNT_W'(1));

  always_comb begin
    state_next     = state;
    occ_next       = occ;
    dump_idx_next  = dump_idx;
    cell_ctl.kind  = CELL_HOLD;
    cell_ctl.value = cmd.item_value;
    cell_slot      = ins_slot;
    res_load       = 1'b0;
    res_value      = '0;
    res_status     = STAT_OK;
    res_count      = occ;
    res_last       = 1'b1;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.op)
            OP_INSERT: begin
              res_load = 1'b1;
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                cell_ctl.kind = CELL_INS;
                cell_slot     = ins_slot;
                occ_next      = occ + CNT_W'(1);
                res_count     = occ + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              res_load = 1'b1;
              if (occ == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                cell_ctl.kind = CELL_DEL;
                cell_slot     = del_slot;
                occ_next      = occ - CNT_W'(1);
                res_count     = occ - CNT_W'(1);
              end
            end
            OP_DUMP: begin
              if (occ == '0) begin
                res_load   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                state_next    = ST_DUMP;
                dump_idx_next = '0;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_DUMP: begin
        // Emit the head and rotate the occupied cells down by one; after
        // occ steps the row is back in its original order.
        if (out_free) begin
          res_load       = 1'b1;
          res_value      = cell_data[0];
          res_last       = (dump_idx == last_idx);
          cell_ctl.kind  = CELL_ROT;
          cell_ctl.value = cell_data[0];
          cell_slot      = last_idx;
          dump_idx_next  = dump_idx + IDX_W'(1);
          if (dump_idx == last_idx) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Row of cells; each sees its neighbors and the broadcast command.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (i == 0) begin : g_lo
      assign left_d = '0;
    end else begin : g_li
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_d = '0;
    end else begin : g_ri
      assign right_d = cell_data[i+1];
    end
    plc_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (cell_ctl),
      .slot  (cell_slot),
      .left  (left_d),
      .right (right_d),
      .data  (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      occ      <= '0;
      dump_idx <= '0;
    end else begin
      state    <= state_next;
      occ      <= occ_next;
      dump_idx <= dump_idx_next;
    end
  end

  // Response register: valid is control, payload loads with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp.out_value   <= res_value;
      rsp.status      <= res_status;
      rsp.entry_count <= ENTRY_W'(res_count);
      rsp.last        <= res_last;
    end
  end

endmodule

`default_nettype wire
